/* hw/rtl/min_window_sum_length_unit_defines.svh */
// assertion macros for the minimum window sum length unit
`ifndef MIN_WINDOW_SUM_LENGTH_UNIT_DEFINES_SVH
`define MIN_WINDOW_SUM_LENGTH_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MWSL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define MWSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mwsl_pkg.sv */
// shared constants and types of the minimum window sum length unit
package mwsl_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 1024;
	localparam int unsigned SAMPLE_WIDTH_DEF = 16;
	localparam int unsigned SAMPLE_FIELD_W   = 16;
	localparam int unsigned LEN_W            = 11;
	localparam int unsigned TARGET_W         = 32;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 32'd1;

	// sequencer status seen by the top level
	typedef struct packed {
		logic empty;
		logic full;
		logic full_drop;
		logic drop;
		logic emit;
	} mwsl_status_t;

endpackage

/* hw/rtl/mwsl_ifs.sv */
// valid/ready channel interfaces for samples, results and configuration
interface mwsl_smp_if import mwsl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [SAMPLE_FIELD_W-1:0] sample;
	logic                      last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface mwsl_res_if import mwsl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] min_length;
	logic             found;

	modport source (output valid, output min_length, output found, input ready);
	modport sink (input valid, input min_length, input found, output ready);
endinterface

interface mwsl_cfg_if import mwsl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/mwsl_ring.sv */
// ring store: one write port, one read port, registered read data (old data on collision)
module mwsl_ring import mwsl_pkg::*; #(
	parameter int unsigned DEPTH  = WINDOW_DEPTH_DEF,
	parameter int unsigned DATA_W = SAMPLE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

/* hw/rtl/mwsl_ctrl.sv */
// window sequencer: pointers, count, sum, best length and result register
module mwsl_ctrl import mwsl_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [SAMPLE_FIELD_W-1:0]       in_sample,
	input  logic                            in_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [LEN_W-1:0]                out_min_length,
	output logic                            out_found,
	input  logic [TARGET_W-1:0]             target,
	output logic                            mem_we,
	output logic [$clog2(WINDOW_DEPTH)-1:0] mem_waddr,
	output logic [SAMPLE_WIDTH-1:0]         mem_wdata,
	output logic [$clog2(WINDOW_DEPTH)-1:0] mem_raddr,
	input  logic [SAMPLE_WIDTH-1:0]         mem_rdata,
	output mwsl_status_t                    status
);

	localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
	localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SUM_W = SAMPLE_WIDTH + AW;
	localparam int unsigned CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FULL  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           head_q;
	logic [AW-1:0]           tail_q;
	logic [CW-1:0]           count_q;
	logic [CMP_W-1:0]        sum_q;
	logic [CW-1:0]           best_q;
	logic                    best_valid_q;
	logic                    last_q;
	logic [SAMPLE_WIDTH-1:0] sample_q;
	logic                    res_valid_q;
	logic [LEN_W-1:0]        res_len_q;
	logic                    res_found_q;

	logic                    accept;
	logic                    is_full;
	logic                    is_empty;
	logic                    hit;
	logic                    better;
	logic                    can_emit;
	logic [AW-1:0]           tail_next;
	logic [SAMPLE_WIDTH-1:0] sample_ext;
	logic [SAMPLE_WIDTH-1:0] tail_data;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		if (p == AW'(WINDOW_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign sample_ext = SAMPLE_WIDTH'(in_sample);
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign is_full    = (count_q == CW'(WINDOW_DEPTH));
	assign is_empty   = (count_q == '0);
	assign tail_next  = ring_next(tail_q);
	// a lone entry is the sample just written, whose read may have seen old data
	assign tail_data  = (count_q == CW'(1)) ? sample_q : mem_rdata;
	assign hit        = !is_empty && (sum_q >= CMP_W'(target));
	assign better     = !best_valid_q || (count_q < best_q);
	assign can_emit   = !res_valid_q || out_ready;

	assign mem_we    = accept;
	assign mem_waddr = head_q;
	assign mem_wdata = sample_ext;
	// prefetch the entry that will be the tail next cycle
	assign mem_raddr = (state_q == ST_IDLE) ? tail_q : tail_next;

	assign out_valid      = res_valid_q;
	assign out_min_length = res_len_q;
	assign out_found      = res_found_q;

	assign status.empty     = is_empty;
	assign status.full      = is_full;
	assign status.full_drop = (state_q == ST_FULL);
	assign status.drop      = (state_q == ST_CHECK) && hit;
	assign status.emit      = (state_q == ST_EMIT) && can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			best_q       <= '0;
			best_valid_q <= 1'b0;
			last_q       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && can_emit) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q <= ring_next(head_q);
						last_q <= in_last;
						if (is_full) begin
							state_q <= ST_FULL;
						end else begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_q + CMP_W'(sample_ext);
							state_q <= ST_CHECK;
						end
					end
				end
				ST_FULL: begin
					// oldest leaves, new sample enters, count unchanged
					sum_q   <= sum_q + CMP_W'(sample_q) - CMP_W'(mem_rdata);
					tail_q  <= tail_next;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (hit) begin
						if (better) begin
							best_q       <= count_q;
							best_valid_q <= 1'b1;
						end
						sum_q   <= sum_q - CMP_W'(tail_data);
						count_q <= count_q - 1'b1;
						tail_q  <= tail_next;
					end else begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (can_emit) begin
						head_q       <= '0;
						tail_q       <= '0;
						count_q      <= '0;
						sum_q        <= '0;
						best_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_ext;
		end
		if ((state_q == ST_EMIT) && can_emit) begin
			res_len_q   <= best_valid_q ? LEN_W'(best_q) : '0;
			res_found_q <= best_valid_q;
		end
	end

endmodule

/* hw/rtl/min_window_sum_length_unit.sv */
// minimum window sum length unit: shortest run of samples whose sum reaches the target
// a sample is taken while idle; on a full ring the oldest entry is evicted first, then the window
//   shrinks while its sum reaches the target, and a last sample loads the result register
// one sample in flight at a time: a new sample is taken only while the sequencer is idle
// reset: asynchronous, clears pointers, count, sum, best length, result valid; target returns to 1
// the ring store has no reset and needs no clearing pass
`include "min_window_sum_length_unit_defines.svh"

module min_window_sum_length_unit import mwsl_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mwsl_smp_if.sink    smp,
	mwsl_res_if.source  res,
	mwsl_cfg_if.sink    cfg
);

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);

	logic [TARGET_W-1:0]     target_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [SAMPLE_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]           mem_raddr;
	logic [SAMPLE_WIDTH-1:0] mem_rdata;
	mwsl_status_t            status;

	// target register: to be written only while the unit is idle; the block itself does not enforce this
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg.valid) begin
			target_q <= cfg.data;
		end
	end

	// sequencer: accepts a sample, then shrinks the window one entry a cycle
	mwsl_ctrl #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (smp.valid),
		.in_ready       (smp.ready),
		.in_sample      (smp.sample),
		.in_last        (smp.last),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.out_min_length (res.min_length),
		.out_found      (res.found),
		.target         (target_q),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata),
		.status         (status)
	);

	// ring of live samples, the oldest read ahead of its removal
	mwsl_ring #(
		.DEPTH  (WINDOW_DEPTH),
		.DATA_W (SAMPLE_WIDTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// a removal never happens on an empty window
	`MWSL_ASSERT_IMPL(a_no_drop_empty, clk, arst_n, status.drop, !status.empty, "drop from empty window")
	// an item taken with a full ring first evicts the oldest entry
	`MWSL_ASSERT_NEXT(a_full_evicts, clk, arst_n, smp.valid && smp.ready && status.full, status.full_drop, "full ring not evicted")
	// once the result is loaded it is presented and the window is clear
	`MWSL_ASSERT_NEXT(a_emit_clears, clk, arst_n, status.emit, res.valid && status.empty, "result not presented or window not cleared")

endmodule

/* sim/testbench.sv */
// testbench for the minimum window sum length unit: directed table, then random sequences
`timescale 1ns / 100ps

module testbench import mwsl_pkg::*; ();

	localparam int unsigned DEPTH        = WINDOW_DEPTH_DEF;
	localparam int unsigned N_ROWS       = 23;
	localparam int unsigned RANDOM_ITEMS = 475;
	localparam int unsigned CALM_ITEMS   = 80;
	localparam int unsigned SETTLE       = 8;

	// one result of the block: shortest length and hit flag
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             hit;
	} outcome_t;

	// one row of the directed table: either a target write or a sample,
	// with an optional hand-written expectation for the result it closes
	typedef struct packed {
		logic                      wr_target;
		logic [TARGET_W-1:0]       goal;
		logic [SAMPLE_FIELD_W-1:0] value;
		logic                      is_last;
		logic                      typed;
		logic [LEN_W-1:0]          len;
		logic                      hit;
	} step_row_t;

	// flavours of random sequence, each pairing a target range with a sample range
	typedef enum int unsigned {
		MIX_TINY,
		MIX_WIDE,
		MIX_ANY,
		MIX_EDGE,
		MIX_LUMPY
	} mix_t;

	localparam step_row_t DIRECTED [0:N_ROWS-1] = '{
		// target is 1 after reset: a zero sample falls short, a one just reaches it
		'{1'b0, 32'd0,          16'd0,     1'b1, 1'b1, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd1,     1'b1, 1'b1, 11'd1, 1'b1},
		'{1'b0, 32'd0,          16'hFFFF,  1'b1, 1'b1, 11'd1, 1'b1},
		// target zero: any non-empty window qualifies, even a zero sample
		'{1'b1, 32'd0,          16'd0,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd0,     1'b1, 1'b1, 11'd1, 1'b1},
		// largest target is out of reach for a short sequence
		'{1'b1, 32'hFFFF_FFFF,  16'd0,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'hFFFF,  1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'hFFFF,  1'b1, 1'b1, 11'd0, 1'b0},
		// textbook case, shrinking several times
		'{1'b1, 32'd7,          16'd0,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd2,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd3,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd1,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd2,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd4,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd3,     1'b1, 1'b0, 11'd0, 1'b0},
		// sum equal to target exactly, with a zero inside the window
		'{1'b1, 32'd100000,     16'd0,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'hFFFF,  1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd0,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd34465, 1'b1, 1'b0, 11'd0, 1'b0},
		// one short of the target, then exactly on it
		'{1'b1, 32'd65536,      16'd0,     1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd32768, 1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd32767, 1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd1,     1'b1, 1'b0, 11'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	mwsl_smp_if smp_ch ();
	mwsl_res_if res_ch ();
	mwsl_cfg_if cfg_ch ();

	min_window_sum_length_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// own copy of the window: live samples oldest first, their sum, best length so far
	logic [SAMPLE_FIELD_W-1:0] window_q [$];
	logic [63:0]               window_total;
	int unsigned               shortest_len;
	bit                        shortest_ok;
	logic [TARGET_W-1:0]       target_now;

	// results still owed by the block, oldest first
	outcome_t    pending_results [$];
	int unsigned errors;

	// idle bursts on both sides are switched off near the end
	bit          jitter_on;
	int unsigned stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hang guard
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// takes one sample into the window; returns 1 and the result when the sample closes a sequence
	function automatic bit advance_window(input logic [SAMPLE_FIELD_W-1:0] s, input logic l,
			output outcome_t res);
		res = '0;
		// full ring: oldest sample leaves before the new one is stored
		if (window_q.size() >= DEPTH)
			window_total -= window_q.pop_front();
		window_q.push_back(s);
		window_total += s;
		// shrink from the old end while the target is met; an empty window stops it
		while (window_q.size() > 0 && window_total >= {32'd0, target_now}) begin
			if (!shortest_ok || window_q.size() < shortest_len) begin
				shortest_len = window_q.size();
				shortest_ok  = 1'b1;
			end
			window_total -= window_q.pop_front();
		end
		if (!l)
			return 1'b0;
		res.len = shortest_ok ? shortest_len[LEN_W-1:0] : '0;
		res.hit = shortest_ok;
		// sequence closed: window back to empty, target kept
		window_q.delete();
		window_total = '0;
		shortest_len = 0;
		shortest_ok  = 1'b0;
		return 1'b1;
	endfunction

	// hands one sample to the block, optionally after a short gap; entered and left at a falling edge
	task automatic send_sample(input logic [SAMPLE_FIELD_W-1:0] s, input logic l,
			input bit typed, input outcome_t typed_res);
		int unsigned gap;
		outcome_t    got;
		if (jitter_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			smp_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp_ch.valid  <= 1'b1;
		smp_ch.sample <= s;
		smp_ch.last   <= l;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		if (advance_window(s, l, got))
			pending_results.push_back(typed ? typed_res : got);
		@(negedge clk);
	endtask

	// target write, only once the block has drained and settled
	task automatic write_target(input logic [TARGET_W-1:0] v);
		smp_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		target_now = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// sample value for a random sequence: some zeros and full-scale values in every flavour
	function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample(input mix_t mix);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (mix == MIX_TINY || mix == MIX_EDGE)
			return SAMPLE_FIELD_W'($urandom_range(0, 15));
		return SAMPLE_FIELD_W'($urandom_range(0, 65535));
	endfunction

	// one sequence of n samples, the final one marked last
	task automatic send_run(input int unsigned n, input mix_t mix);
		int unsigned k;
		for (k = 0; k < n; k++)
			send_sample(pick_sample(mix), k == n - 1, 1'b0, '0);
	endtask

	// result side: ready held low in random bursts, one assignment per falling edge
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (jitter_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: min_length %0d found %0b",
					$time, res_ch.min_length, res_ch.found);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.min_length !== want.len) begin
					$display("%0t: min_length expected %0d actual %0d",
						$time, want.len, res_ch.min_length);
					errors++;
				end
				if (res_ch.found !== want.hit) begin
					$display("%0t: found expected %0b actual %0b",
						$time, want.hit, res_ch.found);
					errors++;
				end
			end
		end
	end

	initial begin
		int unsigned i;
		int unsigned k;
		int unsigned sent;
		int unsigned n_seq;
		int unsigned q;
		mix_t        mix;
		logic [TARGET_W-1:0] goal;

		// everything known from time zero
		arst_n        = 1'b0;
		smp_ch.valid  = 1'b0;
		smp_ch.sample = '0;
		smp_ch.last   = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		jitter_on     = 1'b1;
		errors        = 0;
		window_q.delete();
		window_total  = '0;
		shortest_len  = 0;
		shortest_ok   = 1'b0;
		target_now    = TARGET_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (i = 0; i < N_ROWS; i++) begin
			if (DIRECTED[i].wr_target)
				write_target(DIRECTED[i].goal);
			else
				send_sample(DIRECTED[i].value, DIRECTED[i].is_last, DIRECTED[i].typed,
					'{DIRECTED[i].len, DIRECTED[i].hit});
		end

		// random sequences, mostly short, under varied targets
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mix = mix_t'($urandom_range(0, 4));
			case (mix)
				MIX_TINY:  goal = $urandom_range(1, 64);
				MIX_WIDE:  goal = $urandom_range(1, 300000);
				MIX_ANY:   goal = $urandom;
				MIX_EDGE:  goal = $urandom_range(0, 1);
				default:   goal = $urandom_range(1000, 200000);
			endcase
			write_target(goal);
			n_seq = $urandom_range(1, 6);
			for (q = 0; q < n_seq; q++) begin
				k = $urandom_range(1, 20);
				// no idling in the closing stretch
				if (sent + k >= RANDOM_ITEMS - CALM_ITEMS)
					jitter_on = 1'b0;
				send_run(k, mix);
				sent += k;
			end
		end

		// drain, then give the block time to show any stray result
		smp_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4 * SETTLE) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* min_window_sum_length_unit.f */
+incdir+hw/rtl
hw/rtl/mwsl_pkg.sv
hw/rtl/mwsl_ifs.sv
hw/rtl/mwsl_ring.sv
hw/rtl/mwsl_ctrl.sv
hw/rtl/min_window_sum_length_unit.sv
sim/testbench.sv
